FILE: hdl/vpsm_pkg.sv
// shared constants, types and codes for the vein point set matcher
package vpsm_pkg;

   // set capacity and derived widths
   localparam int MAX_POINTS = 128;
   localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

   // fixed field widths
   localparam int COORD_W  = 8;
   localparam int KIND_W   = 2;
   localparam int DIST_W   = 18;
   localparam int ANGLE_W  = 8;
   localparam int SIM_W    = 17;
   localparam int MATCH_W  = 8;
   localparam int FRAC_W   = 16;
   localparam int QUOT_W   = COUNT_W + FRAC_W;
   localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

   // input word kinds
   localparam logic [KIND_W-1:0] KIND_LOAD_REF   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_PROBE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPARE    = 2'd2;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 18;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_LIMIT = 2'd1;

   // reset values and result constants
   localparam logic [DIST_W-1:0]  DIST_LIMIT_RESET  = 18'd25;
   localparam logic [ANGLE_W-1:0] ANGLE_LIMIT_RESET = 8'd30;
   localparam logic [SIM_W-1:0]   SIM_ONE           = 17'h10000;
   localparam int                 MATCH_MAX         = (1 << MATCH_W) - 1;

   // packed point as stored in the set memories
   typedef struct packed {
      logic [COORD_W-1:0] direction;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_x;
   } point_type;

   localparam int POINT_W = $bits(point_type);

endpackage

FILE: hdl/vein_point_set_matcher_core.sv
// top level of the vein point set matcher: set memories, scan sequencer, result register
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | kind, pos_x, pos_y, direction
//   rsp     | out       | rsp_valid/rsp_ready  | similarity, match_count, overflowed
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// a compare walks the reference set one point at a time and streams the probe set
// past it through the probe memory read port, one pair per cycle, stopping at the
// first close pair; a compare with an empty or overflowed set skips the walk. the
// divider state then produces the 24 quotient bits and the done flag, and the
// result goes to the result register.
// req_ready is high only while the sequencer is idle; loads are still taken while a
// result waits on rsp. a compare holds in its last step until the result register
// is free. sync reset clears counts and flags, presets limits; no clearing pass.
module vein_point_set_matcher_core
   import vpsm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request words
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [COORD_W-1:0]     req_pos_x,
   input  logic [COORD_W-1:0]     req_pos_y,
   input  logic [COORD_W-1:0]     req_direction,
   // response words
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SIM_W-1:0]       rsp_similarity,
   output logic [MATCH_W-1:0]     rsp_match_count,
   output logic                   rsp_overflowed,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RDREF = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   ref_count_ff, ref_count_in;
   logic [COUNT_W-1:0]   probe_count_ff, probe_count_in;
   logic                 ovf_ff, ovf_in;
   logic [ADDR_W-1:0]    idx_i_ff, idx_i_in;
   logic [COUNT_W-1:0]   idx_j_ff, idx_j_in;
   logic [COUNT_W-1:0]   matches_ff, matches_in;
   logic [DIST_W-1:0]    dist_limit_ff, dist_limit_in;
   logic [ANGLE_W-1:0]   angle_limit_ff, angle_limit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SIM_W-1:0]     rsp_sim_ff, rsp_sim_in;
   logic [MATCH_W-1:0]   rsp_match_ff, rsp_match_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic                 req_fire;
   logic                 csr_fire;
   logic                 slot_free;
   point_type            req_point;
   point_type            ref_rd_point;
   point_type            probe_rd_point;
   logic                 ref_wr_en;
   logic                 probe_wr_en;
   logic                 pair_close;
   logic                 div_start;
   logic                 div_done;
   logic [QUOT_W-1:0]    div_quot;
   logic [COUNT_W:0]     count_sum;
   logic [COUNT_W-1:0]   total;
   logic                 last_ref;
   logic                 last_probe;
   logic [SIM_W-1:0]     sim_value;

   assign req_fire  = req_valid & req_ready;
   assign csr_fire  = csr_valid & csr_ready;
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   assign req_point.pos_x     = req_pos_x;
   assign req_point.pos_y     = req_pos_y;
   assign req_point.direction = req_direction;

   // load writes go to the next free entry of the chosen set
   assign ref_wr_en   = req_fire && (req_kind == KIND_LOAD_REF)
                        && (ref_count_ff < COUNT_W'(MAX_POINTS));
   assign probe_wr_en = req_fire && (req_kind == KIND_LOAD_PROBE)
                        && (probe_count_ff < COUNT_W'(MAX_POINTS));

   // reference set memory, read at the current reference index
   vpsm_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_wr_en),
      .wr_addr (ref_count_ff[ADDR_W-1:0]),
      .wr_data (req_point),
      .rd_addr (idx_i_ff),
      .rd_data (ref_rd_point)
   );

   // probe set memory, streamed by the probe index
   vpsm_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_probe_ram (
      .clock   (clock),
      .wr_en   (probe_wr_en),
      .wr_addr (probe_count_ff[ADDR_W-1:0]),
      .wr_data (req_point),
      .rd_addr (idx_j_ff[ADDR_W-1:0]),
      .rd_data (probe_rd_point)
   );

   // pair test on the memory outputs
   vpsm_pair u_pair (
      .ref_point   (ref_rd_point),
      .probe_point (probe_rd_point),
      .dist_limit  (dist_limit_ff),
      .angle_limit (angle_limit_ff),
      .close       (pair_close)
   );

   // average set size, floored
   assign count_sum = {1'b0, ref_count_ff} + {1'b0, probe_count_ff};
   assign total     = count_sum[COUNT_W:1];

   // match ratio divider
   vpsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({matches_in, {FRAC_W{1'b0}}}),
      .divisor  (total),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign last_ref   = ({1'b0, idx_i_ff} + 1'b1) == (ADDR_W+1)'(ref_count_ff);
   assign last_probe = (idx_j_ff == probe_count_ff);

   // similarity with clamp, zeroed on overflow or empty average
   always_comb begin
      if (ovf_ff || (total == '0)) begin
         sim_value = '0;
      end else if (div_quot > QUOT_W'(SIM_ONE)) begin
         sim_value = SIM_ONE;
      end else begin
         sim_value = SIM_W'(div_quot);
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      ref_count_in   = ref_count_ff;
      probe_count_in = probe_count_ff;
      ovf_in         = ovf_ff;
      idx_i_in       = idx_i_ff;
      idx_j_in       = idx_j_ff;
      matches_in     = matches_ff;
      div_start      = 1'b0;
      rsp_sim_in     = rsp_sim_ff;
      rsp_match_in   = rsp_match_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_valid_in   = rsp_ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  KIND_LOAD_REF: begin
                     if (ref_wr_en) begin
                        ref_count_in = ref_count_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  KIND_LOAD_PROBE: begin
                     if (probe_wr_en) begin
                        probe_count_in = probe_count_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  KIND_COMPARE: begin
                     matches_in = '0;
                     idx_i_in   = '0;
                     idx_j_in   = '0;
                     if (!ovf_ff && (ref_count_ff != '0) && (probe_count_ff != '0)) begin
                        state_in = ST_RDREF;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RDREF: begin
            // reference point and probe entry zero are being read
            idx_j_in = COUNT_W'(1);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (pair_close || last_probe) begin
               if (pair_close) begin
                  matches_in = matches_ff + 1'b1;
               end
               idx_j_in = '0;
               if (last_ref) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  idx_i_in = idx_i_ff + 1'b1;
                  state_in = ST_RDREF;
               end
            end else begin
               idx_j_in = idx_j_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_sim_in   = sim_value;
               rsp_ovf_in   = ovf_ff;
               if (ovf_ff) begin
                  rsp_match_in = '0;
               end else if (int'(matches_ff) > MATCH_MAX) begin
                  rsp_match_in = MATCH_W'(MATCH_MAX);
               end else begin
                  rsp_match_in = MATCH_W'(matches_ff);
               end
               ref_count_in   = '0;
               probe_count_in = '0;
               ovf_in         = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // register writes
   always_comb begin
      dist_limit_in  = dist_limit_ff;
      angle_limit_in = angle_limit_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_DIST_LIMIT:  dist_limit_in  = DIST_W'(csr_wdata);
            CSR_ANGLE_LIMIT: angle_limit_in = ANGLE_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ref_count_ff   <= '0;
         probe_count_ff <= '0;
         ovf_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         dist_limit_ff  <= DIST_LIMIT_RESET;
         angle_limit_ff <= ANGLE_LIMIT_RESET;
      end else begin
         state_ff       <= state_in;
         ref_count_ff   <= ref_count_in;
         probe_count_ff <= probe_count_in;
         ovf_ff         <= ovf_in;
         rsp_valid_ff   <= rsp_valid_in;
         dist_limit_ff  <= dist_limit_in;
         angle_limit_ff <= angle_limit_in;
      end
   end

   // scan indexes and result word
   always_ff @(posedge clock) begin
      idx_i_ff     <= idx_i_in;
      idx_j_ff     <= idx_j_in;
      matches_ff   <= matches_in;
      rsp_sim_ff   <= rsp_sim_in;
      rsp_match_ff <= rsp_match_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_similarity  = rsp_sim_ff;
   assign rsp_match_count = rsp_match_ff;
   assign rsp_overflowed  = rsp_ovf_ff;

endmodule

FILE: hdl/vpsm_ram.sv
// generic single write port, single read port ram with registered read
module vpsm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/vpsm_pair.sv
// closeness test of one reference point against one probe point
module vpsm_pair
   import vpsm_pkg::*;
(
   input  point_type           ref_point,
   input  point_type           probe_point,
   input  logic [DIST_W-1:0]   dist_limit,
   input  logic [ANGLE_W-1:0]  angle_limit,
   output logic                close
);

   logic [COORD_W-1:0]   dx;
   logic [COORD_W-1:0]   dy;
   logic [COORD_W-1:0]   da;
   logic [2*COORD_W-1:0] dx_sq;
   logic [2*COORD_W-1:0] dy_sq;
   logic [DIST_W-1:0]    dist_sq;
   logic [COORD_W:0]     da_wrap;
   logic                 dist_ok;
   logic                 angle_ok;

   // absolute differences
   always_comb begin
      dx = (ref_point.pos_x > probe_point.pos_x) ? ref_point.pos_x - probe_point.pos_x
                                                 : probe_point.pos_x - ref_point.pos_x;
      dy = (ref_point.pos_y > probe_point.pos_y) ? ref_point.pos_y - probe_point.pos_y
                                                 : probe_point.pos_y - ref_point.pos_y;
      da = (ref_point.direction > probe_point.direction)
           ? ref_point.direction - probe_point.direction
           : probe_point.direction - ref_point.direction;
   end

   // squared distance against the limit
   always_comb begin
      dx_sq   = dx * dx;
      dy_sq   = dy * dy;
      dist_sq = DIST_W'(dx_sq) + DIST_W'(dy_sq);
      dist_ok = dist_sq < dist_limit;
   end

   // direction difference wrapped onto the short way round the circle
   always_comb begin
      if (da > COORD_W'(1 << (COORD_W - 1))) begin
         da_wrap = (COORD_W+1)'(1 << COORD_W) - {1'b0, da};
      end else begin
         da_wrap = {1'b0, da};
      end
      angle_ok = da_wrap < {1'b0, angle_limit};
   end

   assign close = dist_ok & angle_ok;

endmodule

FILE: hdl/vpsm_div.sv
// restoring divider, one quotient bit per cycle
module vpsm_div
   import vpsm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [QUOT_W-1:0]  dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               done,
   output logic [QUOT_W-1:0]  quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [QUOT_W-1:0]    quo_ff, quo_in;
   logic [COUNT_W:0]     trial;

   // one shift and subtract step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[QUOT_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(QUOT_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = COUNT_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = COUNT_W'(trial);
            quo_in = {quo_ff[QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
